[src/lats_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lats_pkg: shared types and constants of the torus life stepper
// Holds opcodes, configuration register indexes, controller states, the
// datapath command beat and the neighbor-count rule constants.
// ============================================================================
package lats_pkg;

  // Default grid geometry.
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Configuration port.
  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS = 1'd1;
  localparam logic [CFG_W-1:0]       SIZE_RESET = 7'd10;

  // Input field widths.
  localparam int OPCODE_W = 2;
  localparam int COORD_W  = 6;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_TOGGLE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 2'd2;

  // Neighbor counts of the life rule.
  localparam logic [3:0] NEIGH_TWO   = 4'd2;
  localparam logic [3:0] NEIGH_THREE = 4'd3;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_FINAL,
    ST_WAIT
  } state_t;

  // Action the datapath takes on the row that returns from memory.
  typedef enum logic [3:0] {
    TAG_NONE,
    TAG_LOAD_UP,
    TAG_LOAD_MID,
    TAG_STEP,
    TAG_FINAL,
    TAG_TOGGLE,
    TAG_READ,
    TAG_BAD,
    TAG_NULL
  } tag_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic rd_en;
    tag_t tag;
  } cmd_t;

endpackage : lats_pkg
`default_nettype wire

[src/lats_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lats_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module lats_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : lats_ram
`default_nettype wire

[src/lats_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lats_ctrl: controller of the torus life stepper
// Holds the size registers, decodes each beat, and sequences the row
// sweep of a generation step as memory reads tagged for the datapath.
// ============================================================================
module lats_ctrl #(
  parameter int MAX_COLS = lats_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lats_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  output logic                                               busy,
  input  wire logic [lats_pkg::OPCODE_W-1:0]                 in_opcode,
  input  wire logic [lats_pkg::COORD_W-1:0]                  in_col,
  input  wire logic [lats_pkg::COORD_W-1:0]                  in_row,
  input  wire logic                                          cfg_we,
  input  wire logic [lats_pkg::CFG_INDEX_W-1:0]              cfg_index,
  input  wire logic [lats_pkg::CFG_W-1:0]                    cfg_wdata,
  output lats_pkg::cmd_t                                     cmd,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_row,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_idx,
  output logic [$clog2(MAX_COLS + 1)-1:0]                    nc
);

  import lats_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NCW = $clog2(MAX_COLS + 1);
  localparam int NRW = $clog2(MAX_ROWS + 1);

  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  state_t           state_r, state_nxt;
  logic [NRW-1:0]   k_r, k_nxt;
  logic [NRW-1:0]   nr;
  logic [RIW-1:0]   nr_m1;
  logic             coord_bad;

  // Size registers; the user writes them only while idle, the block itself does not enforce it.
  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_nxt = cfg_wdata;
        CFG_ROWS: rows_nxt = cfg_wdata;
        default: begin
          cols_nxt = cols_r;
          rows_nxt = rows_r;
        end
      endcase
    end
  end

  // Clamp the sizes in use: zero acts as one, anything too big as the maximum.
  always_comb begin
    if (cols_r == '0) begin
      nc = NCW'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_r);
    end
    if (rows_r == '0) begin
      nr = NRW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_r);
    end
  end

  assign nr_m1     = RIW'(nr - NRW'(1));
  assign coord_bad = (32'(in_col) >= 32'(nc)) || (32'(in_row) >= 32'(nr));
  assign busy      = (state_r != ST_IDLE);

  // State register and sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      cols_r  <= SIZE_RESET;
      rows_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
    end
  end

  // Next state and commands. A generation step reads the last row first,
  // then rows zero up to the last again; each read carries the action the
  // datapath applies when its data returns.
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    cmd.rd_en   = 1'b0;
    cmd.tag     = TAG_NONE;
    rd_addr     = '0;
    wr_row      = '0;
    col_idx     = CIW'(in_col);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_TOGGLE, OP_READ: begin
              if (coord_bad) begin
                cmd.tag = TAG_BAD;
              end else begin
                cmd.rd_en = 1'b1;
                cmd.tag   = (in_opcode == OP_TOGGLE) ? TAG_TOGGLE : TAG_READ;
                rd_addr   = RIW'(in_row);
                wr_row    = RIW'(in_row);
              end
              state_nxt = ST_WAIT;
            end
            OP_ADVANCE: begin
              k_nxt     = '0;
              state_nxt = ST_ADV;
            end
            default: begin
              cmd.tag   = TAG_NULL;
              state_nxt = ST_WAIT;
            end
          endcase
        end
      end
      ST_ADV: begin
        cmd.rd_en = 1'b1;
        if (k_r == NRW'(0)) begin
          rd_addr = nr_m1;
          cmd.tag = TAG_LOAD_UP;
        end else if (k_r == NRW'(1)) begin
          rd_addr = RIW'(k_r - NRW'(1));
          cmd.tag = TAG_LOAD_MID;
        end else begin
          rd_addr = RIW'(k_r - NRW'(1));
          wr_row  = RIW'(k_r - NRW'(2));
          cmd.tag = TAG_STEP;
        end
        if (k_r == nr) begin
          state_nxt = ST_FINAL;
        end
        k_nxt = k_r + NRW'(1);
      end
      ST_FINAL: begin
        cmd.tag   = TAG_FINAL;
        wr_row    = nr_m1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted beat always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("lats_ctrl: block not busy after accepting a beat");

  // The sweep counter never runs past the last read of a generation step.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADV) |-> (k_r <= nr))
    else $error("lats_ctrl: sweep counter past the rows in use");
`endif

endmodule : lats_ctrl
`default_nettype wire

[src/lats_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lats_dpath: datapath of the torus life stepper
// Grid memory with per-row valid bits, a three-row window, one lane of
// neighbor counting per column, and the registered result beat.
// ============================================================================
module lats_dpath #(
  parameter int MAX_COLS = lats_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lats_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire lats_pkg::cmd_t                                cmd,
  input  wire logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rd_addr,
  input  wire logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_row,
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_idx,
  input  wire logic [$clog2(MAX_COLS + 1)-1:0]               nc,
  output logic                                               out_strobe,
  output logic                                               out_cell_value,
  output logic                                               out_bad_coord
);

  import lats_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NCW = $clog2(MAX_COLS + 1);

  tag_t                tag_r;
  logic [RIW-1:0]      wr_row_r;
  logic [CIW-1:0]      col_r;
  logic                rvalid_r;
  logic [MAX_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [MAX_COLS-1:0] up_r, up_nxt;
  logic [MAX_COLS-1:0] mid_r, mid_nxt;
  logic [MAX_COLS-1:0] top_r, top_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic                out_cell_r, out_cell_nxt;
  logic                out_bad_r, out_bad_nxt;

  logic [MAX_COLS-1:0] ram_rdata;
  logic [MAX_COLS-1:0] row_d;
  logic [MAX_COLS-1:0] down_row;
  logic [MAX_COLS-1:0] next_row;
  logic [MAX_COLS-1:0] ram_wdata;
  logic                ram_we;
  logic [CIW-1:0]      nc_m1;
  logic                up_hi, mid_hi, down_hi;

  // Grid memory, one row of cells per entry.
  lats_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_row_r),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // A row never written since reset reads as all dead.
  assign row_d = rvalid_r ? ram_rdata : '0;

  // Action tag, rows and column travel with the read to the data beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r        <= TAG_NONE;
      row_valid_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      tag_r        <= cmd.tag;
      row_valid_r  <= row_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_row_r   <= wr_row;
    col_r      <= col_idx;
    rvalid_r   <= row_valid_r[rd_addr];
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    top_r      <= top_nxt;
    out_cell_r <= out_cell_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // Wrap bits at the right edge of the columns in use.
  assign nc_m1    = CIW'(nc - NCW'(1));
  assign down_row = (tag_r == TAG_FINAL) ? top_r : row_d;
  assign up_hi    = up_r[nc_m1];
  assign mid_hi   = mid_r[nc_m1];
  assign down_hi  = down_row[nc_m1];

  // One lane per column: count the eight neighbors and apply the rule.
  // Columns outside the window keep their cells.
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    logic       ul, ur, ml, mr, dl, dr;
    logic       at_hi;
    logic [3:0] cnt;
    logic       nv;

    assign at_hi = (CIW'(c) == nc_m1);

    if (c == 0) begin : g_left_wrap
      assign ul = up_hi;
      assign ml = mid_hi;
      assign dl = down_hi;
    end else begin : g_left
      assign ul = up_r[c-1];
      assign ml = mid_r[c-1];
      assign dl = down_row[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_wrap
      assign ur = up_r[0];
      assign mr = mid_r[0];
      assign dr = down_row[0];
    end else begin : g_right
      assign ur = at_hi ? up_r[0]     : up_r[c+1];
      assign mr = at_hi ? mid_r[0]    : mid_r[c+1];
      assign dr = at_hi ? down_row[0] : down_row[c+1];
    end

    assign cnt = 4'(ul) + 4'(up_r[c]) + 4'(ur) + 4'(ml) + 4'(mr)
               + 4'(dl) + 4'(down_row[c]) + 4'(dr);
    assign nv  = mid_r[c] ? ((cnt == NEIGH_TWO) || (cnt == NEIGH_THREE))
                          : (cnt == NEIGH_THREE);
    assign next_row[c] = (NCW'(c) < nc) ? nv : mid_r[c];
  end

  // Act on the returning row.
  always_comb begin
    up_nxt         = up_r;
    mid_nxt        = mid_r;
    top_nxt        = top_r;
    ram_we         = 1'b0;
    ram_wdata      = next_row;
    row_valid_nxt  = row_valid_r;
    out_strobe_nxt = 1'b0;
    out_cell_nxt   = 1'b0;
    out_bad_nxt    = 1'b0;
    case (tag_r)
      TAG_LOAD_UP: begin
        up_nxt = row_d;
      end
      TAG_LOAD_MID: begin
        mid_nxt = row_d;
        top_nxt = row_d;
      end
      TAG_STEP: begin
        ram_we  = 1'b1;
        up_nxt  = mid_r;
        mid_nxt = row_d;
      end
      TAG_FINAL: begin
        ram_we         = 1'b1;
        out_strobe_nxt = 1'b1;
      end
      TAG_TOGGLE: begin
        ram_we         = 1'b1;
        ram_wdata      = row_d ^ (MAX_COLS'(1) << col_r);
        out_strobe_nxt = 1'b1;
        out_cell_nxt   = ~row_d[col_r];
      end
      TAG_READ: begin
        out_strobe_nxt = 1'b1;
        out_cell_nxt   = row_d[col_r];
      end
      TAG_BAD: begin
        out_strobe_nxt = 1'b1;
        out_bad_nxt    = 1'b1;
      end
      TAG_NULL: begin
        out_strobe_nxt = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    if (ram_we) begin
      row_valid_nxt[wr_row_r] = 1'b1;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_cell_value = out_cell_r;
  assign out_bad_coord  = out_bad_r;

`ifndef SYNTHESIS
  // A row is never read in the cycle that it is written back.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && ram_we) |-> (rd_addr != wr_row_r))
    else $error("lats_dpath: read and write of the same row in one cycle");

  // A flagged coordinate never reports a live cell.
  a_bad_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_bad_r |-> !out_cell_r)
    else $error("lats_dpath: bad coordinate beat carries a live cell");
`endif

endmodule : lats_dpath
`default_nettype wire

[src/life_automaton_torus_stepper_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// life_automaton_torus_stepper_core: Conway life stepper on a torus
// Toggle, read, or advance one generation of a one-bit cell grid.
// ============================================================================
// Toggle, read, bad coordinate and unused opcode: result strobe after the
//   action tag and result registers; the next beat is taken then.
// Advance: result strobe after the full row sweep, the next beat is taken
//   then; the sweep reads one grid row per cycle from memory.
// Reset (synchronous): all cells dead through per-row valid bits, with no
//   clearing pass; both sizes return to 10. Results cannot be stalled.
module life_automaton_torus_stepper_core #(
  parameter int MAX_COLS = lats_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lats_pkg::MAX_ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [lats_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [lats_pkg::COORD_W-1:0]     in_col,
  input  wire logic [lats_pkg::COORD_W-1:0]     in_row,
  output logic                                  out_strobe,
  output logic                                  out_cell_value,
  output logic                                  out_bad_coord,
  input  wire logic                             cfg_we,
  input  wire logic [lats_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lats_pkg::CFG_W-1:0]       cfg_wdata
);

  import lats_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NCW = $clog2(MAX_COLS + 1);

  cmd_t           cmd;
  logic [RIW-1:0] rd_addr;
  logic [RIW-1:0] wr_row;
  logic [CIW-1:0] col_idx;
  logic [NCW-1:0] nc;

  // Controller: size registers, decode and row sweep sequencing.
  lats_ctrl #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_opcode(in_opcode),
    .in_col   (in_col),
    .in_row   (in_row),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_row   (wr_row),
    .col_idx  (col_idx),
    .nc       (nc)
  );

  // Datapath: grid memory, row window, column lanes and result register.
  lats_dpath #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .wr_row        (wr_row),
    .col_idx       (col_idx),
    .nc            (nc),
    .out_strobe    (out_strobe),
    .out_cell_value(out_cell_value),
    .out_bad_coord (out_bad_coord)
  );

endmodule : life_automaton_torus_stepper_core
`default_nettype wire

[dv/life_automaton_torus_stepper_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// life_automaton_torus_stepper_core_tb: self-checking bench of the life stepper
// A directed table at the reset window is followed by random phases over
// many window sizes, with extremes and out-of-range register values. Every
// accepted beat runs through a local grid predictor. Every result strobe is
// checked against the oldest pending expectation.
// ============================================================================
module life_automaton_torus_stepper_core_tb;
  import lats_pkg::*;

  localparam int GRID_COLS     = 64;
  localparam int GRID_ROWS     = 64;
  localparam int RANDOM_BEATS  = 1200;
  localparam int CALM_BEATS    = 150;
  localparam int N_PHASES      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_LIMIT   = 400;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Result of one beat, as the block reports it.
  typedef struct packed {
    logic cell_value;
    logic bad_coord;
  } cell_result_t;

  // One row of the directed table.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    bit                  fixed;
    cell_result_t        result;
  } stim_row_t;

  // Window sizes of the random phases; zero and above 64 test clamping.
  // Phases marked with 0 in phase_fixed get random sizes.
  localparam int PHASE_COLS [N_PHASES] = '{64, 1, 2, 1, 64, 2, 0, 127, 65, 5, 3, 0, 0, 12};
  localparam int PHASE_ROWS [N_PHASES] = '{64, 1, 2, 64, 1, 7, 0, 127, 3, 2, 100, 0, 0, 9};
  localparam bit PHASE_FIXED [N_PHASES] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 1};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OPCODE_W-1:0]    in_opcode = '0;
  logic [COORD_W-1:0]     in_col = '0;
  logic [COORD_W-1:0]     in_row = '0;
  logic                   out_strobe;
  logic                   out_cell_value;
  logic                   out_bad_coord;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  // Predictor state: grid indexed [row][col] and the two size registers.
  bit [GRID_COLS-1:0] life_grid [GRID_ROWS];
  logic [CFG_W-1:0]   cols_reg;
  logic [CFG_W-1:0]   rows_reg;

  cell_result_t pending_cells [$];
  stim_row_t    stim_rows [$];

  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int toggles = 0;
  int reads = 0;
  int advances = 0;
  int unused_ops = 0;
  int bad_coords = 0;
  int windows = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;
  cell_result_t want;

  life_automaton_torus_stepper_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_strobe     (out_strobe),
    .out_cell_value (out_cell_value),
    .out_bad_coord  (out_bad_coord),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Size actually used for a register value: 0 acts as 1, large values clamp.
  function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // One generation over the window; cells outside it keep their values.
  // Wrapped neighbors that repeat on narrow windows are counted each time.
  function automatic void advance_grid();
    bit [GRID_COLS-1:0] nxt [GRID_ROWS];
    int unsigned nc, nr, cl, cr, ru, rd, live;
    nc = span(cols_reg, GRID_COLS);
    nr = span(rows_reg, GRID_ROWS);
    nxt = life_grid;
    for (int unsigned r = 0; r < nr; r++) begin
      for (int unsigned c = 0; c < nc; c++) begin
        cl = (c == 0) ? nc - 1 : c - 1;
        cr = (c + 1 >= nc) ? 0 : c + 1;
        ru = (r == 0) ? nr - 1 : r - 1;
        rd = (r + 1 >= nr) ? 0 : r + 1;
        live = life_grid[ru][cl] + life_grid[ru][c] + life_grid[ru][cr]
             + life_grid[r][cl]  + life_grid[r][c]  + life_grid[r][cr]
             + life_grid[rd][cl] + life_grid[rd][c] + life_grid[rd][cr];
        if (life_grid[r][c]) begin
          nxt[r][c] = (live - 1 == NEIGH_TWO) || (live - 1 == NEIGH_THREE);
        end else begin
          nxt[r][c] = (live == NEIGH_THREE);
        end
      end
    end
    life_grid = nxt;
  endfunction

  // Applies one accepted beat to the predictor and returns its result.
  function automatic cell_result_t apply_beat(logic [OPCODE_W-1:0] op,
                                              logic [COORD_W-1:0] col,
                                              logic [COORD_W-1:0] row);
    cell_result_t res;
    res = '0;
    case (op)
      OP_TOGGLE, OP_READ: begin
        if (col >= span(cols_reg, GRID_COLS) || row >= span(rows_reg, GRID_ROWS)) begin
          res.bad_coord = 1'b1;
        end else begin
          if (op == OP_TOGGLE) life_grid[row][col] = ~life_grid[row][col];
          res.cell_value = life_grid[row][col];
        end
      end
      OP_ADVANCE: begin
        advance_grid();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Drives one beat, waits for acceptance, records the expected result and
  // may then leave a random gap.
  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input bit fixed = 1'b0,
                           input cell_result_t fixed_res = '0);
    cell_result_t res;
    start <= 1'b1;
    in_opcode <= op;
    in_col <= col;
    in_row <= row;
    do @(posedge clk); while (busy);
    res = apply_beat(op, col, row);
    pending_cells.push_back(fixed ? fixed_res : res);
    beats_sent++;
    if (res.bad_coord) bad_coords++;
    case (op)
      OP_TOGGLE:  toggles++;
      OP_READ:    reads++;
      OP_ADVANCE: advances++;
      default:    unused_ops++;
    endcase
    if ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers while the block is idle.
  task automatic set_window(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cols_reg = cols;
    cfg_index <= CFG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_we <= 1'b0;
    windows++;
  endtask

  task automatic add_row(input logic [OPCODE_W-1:0] op, input int col, input int row,
                         input bit fixed, input bit val, input bit bad);
    stim_row_t sr;
    sr.opcode = op;
    sr.col = COORD_W'(col);
    sr.row = COORD_W'(row);
    sr.fixed = fixed;
    sr.result.cell_value = val;
    sr.result.bad_coord = bad;
    stim_rows.push_back(sr);
  endtask

  // Result checker: every strobe is one beat, compared to the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_cells.size() == 0) begin
        errors++;
        $display("%0t ns: result with no beat pending, cell_value %b bad_coord %b",
                 $time, out_cell_value, out_bad_coord);
      end else begin
        want = pending_cells.pop_front();
        if (out_cell_value !== want.cell_value) begin
          errors++;
          $display("%0t ns: cell_value mismatch, expected %b, actual %b",
                   $time, want.cell_value, out_cell_value);
        end
        if (out_bad_coord !== want.bad_coord) begin
          errors++;
          $display("%0t ns: bad_coord mismatch, expected %b, actual %b",
                   $time, want.bad_coord, out_bad_coord);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: watchdog, no beat or result for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned nc, nr, cc, rc, quota, phase_start, kind, wait_cycles;
    logic [CFG_W-1:0] wc, wr;

    foreach (life_grid[r]) life_grid[r] = '0;
    cols_reg = SIZE_RESET;
    rows_reg = SIZE_RESET;

    // Directed table at the reset window of 10 by 10.
    add_row(OP_READ,    0,  0, 1, 0, 0);
    add_row(OP_TOGGLE,  0,  0, 1, 1, 0);
    add_row(OP_READ,    0,  0, 1, 1, 0);
    add_row(OP_TOGGLE,  0,  0, 1, 0, 0);
    add_row(OP_READ,   10,  0, 1, 0, 1);
    add_row(OP_READ,    0, 10, 1, 0, 1);
    add_row(OP_TOGGLE, 63, 63, 1, 0, 1);
    add_row(OP_TOGGLE,  9,  9, 1, 1, 0);
    add_row(OP_UNUSED, 63, 63, 1, 0, 0);
    add_row(OP_ADVANCE, 63, 63, 1, 0, 0);
    add_row(OP_READ,    9,  9, 0, 0, 0);
    // A blinker lying across the column wrap turns into one across the row wrap.
    add_row(OP_TOGGLE,  9,  0, 0, 0, 0);
    add_row(OP_TOGGLE,  0,  0, 0, 0, 0);
    add_row(OP_TOGGLE,  1,  0, 0, 0, 0);
    add_row(OP_ADVANCE, 0,  0, 1, 0, 0);
    add_row(OP_READ,    0,  9, 0, 0, 0);
    add_row(OP_READ,    0,  0, 0, 0, 0);
    add_row(OP_READ,    0,  1, 0, 0, 0);
    add_row(OP_READ,    9,  0, 0, 0, 0);
    add_row(OP_ADVANCE, 0,  0, 0, 0, 0);
    add_row(OP_READ,    9,  0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 30;
    foreach (stim_rows[i]) begin
      send_beat(stim_rows[i].opcode, stim_rows[i].col, stim_rows[i].row,
                stim_rows[i].fixed, stim_rows[i].result);
    end

    // Random phases, each with its own window and idling rate.
    for (int p = 0; p < N_PHASES; p++) begin
      if (PHASE_FIXED[p]) begin
        wc = CFG_W'(PHASE_COLS[p]);
        wr = CFG_W'(PHASE_ROWS[p]);
      end else begin
        wc = CFG_W'($urandom_range(GRID_COLS, 1));
        wr = CFG_W'($urandom_range(GRID_ROWS, 1));
      end
      set_window(wc, wr);
      nc = span(cols_reg, GRID_COLS);
      nr = span(rows_reg, GRID_ROWS);
      if (p == N_PHASES - 1) begin
        idle_pct = 0;
        quota = CALM_BEATS;
      end else begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
        quota = (RANDOM_BEATS - CALM_BEATS) / (N_PHASES - 1);
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < quota) begin
        kind = $urandom_range(99, 0);
        if (kind < 65) begin
          // Seed a small cluster, let it evolve, then read it back.
          cc = $urandom_range(nc - 1, 0);
          rc = $urandom_range(nr - 1, 0);
          repeat ($urandom_range(12, 3)) begin
            send_beat(OP_TOGGLE, COORD_W'((cc + $urandom_range(4, 0)) % nc),
                      COORD_W'((rc + $urandom_range(4, 0)) % nr));
          end
          repeat ($urandom_range(4, 1)) begin
            send_beat(OP_ADVANCE, COORD_W'($urandom), COORD_W'($urandom));
          end
          repeat ($urandom_range(8, 2)) begin
            send_beat(OP_READ, COORD_W'((cc + $urandom_range(4, 0)) % nc),
                      COORD_W'((rc + $urandom_range(4, 0)) % nr));
          end
        end else if (kind < 97) begin
          // Noise over every opcode and the full coordinate range.
          repeat ($urandom_range(6, 1)) begin
            send_beat(OPCODE_W'($urandom_range(3, 0)), COORD_W'($urandom_range(63, 0)),
                      COORD_W'($urandom_range(63, 0)));
          end
        end else begin
          drain();
        end
      end
    end

    // Wait for the last results, then a few more cycles for strays.
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_cells.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (pending_cells.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, pending_cells.size());
    end

    $display("Ran %0d beats over %0d window settings: %0d toggles, %0d reads, %0d advances,",
             beats_sent, windows, toggles, reads, advances);
    $display("%0d unused opcodes, %0d out-of-window coordinates; %0d results checked, %0d errors.",
             unused_ops, bad_coords, results_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
